// ===== rtl/harmonic_path_action_difference_top_macros.svh =====
// assertion macros for the harmonic path action difference block
`ifndef HARMONIC_PATH_ACTION_DIFFERENCE_TOP_MACROS_SVH
`define HARMONIC_PATH_ACTION_DIFFERENCE_TOP_MACROS_SVH

// property checked at every clock edge outside reset
`define HPAD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define HPAD_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/hpad_pkg.sv =====
// types, constants and helpers for the harmonic path action difference block
package hpad_pkg;

    localparam int COORD_W = 24;
    localparam int CTR_W   = 25;
    localparam int COEF_W  = 32;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 66;
    localparam int SUM_W   = 52;
    localparam int DOT_W   = 40;
    localparam int ACC_W   = 64;
    localparam int FULL_W  = 72;
    localparam int FRAC_W  = 16;
    localparam int NUM_DIMS = 3;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_DIAG      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_CROSS     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_KIN       = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PARTICLE = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_COUNT = 4'd7;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // sequencer states
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_DOT   = 8'b0000_0010,
        ST_TRUNC = 8'b0000_0100,
        ST_SCALE = 8'b0000_1000,
        ST_SUB1  = 8'b0001_0000,
        ST_SUB2  = 8'b0010_0000,
        ST_ACC   = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } t_state;

    // what a product in flight is for
    typedef enum logic [2:0] {
        MOP_AA,
        MOP_AB,
        MOP_BB,
        MOP_LO,
        MOP_HI
    } t_mop;

    typedef struct packed {
        logic       vld;
        t_mop       op;
        logic [1:0] ci;
    } t_mtag;

    typedef struct packed {
        logic signed [ACC_W-1:0] val;
        logic                    ovf;
    } t_sat;

    // saturating 64-bit add or subtract
    function automatic t_sat f_sat_addsub(input logic signed [ACC_W-1:0] a,
                                          input logic signed [ACC_W-1:0] b,
                                          input logic                    sub);
        logic signed [ACC_W:0] s;
        t_sat                  r;
        s = sub ? ((ACC_W+1)'(a) - (ACC_W+1)'(b)) : ((ACC_W+1)'(a) + (ACC_W+1)'(b));
        if (s[ACC_W] != s[ACC_W-1]) begin
            r.ovf = 1'b1;
            r.val = s[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            r.ovf = 1'b0;
            r.val = s[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/harmonic_path_action_difference_top.sv =====
// Harmonic oscillator path action difference: accumulates the fixed-point action of a stream
// of path links and hands out the saturated Q32.32 total on the link marked last. A link
// whose particle lies in range holds the input stalled until it is through: the single shared
// 33x33 multiplier forms 3 products per dimension and 6 partial products for the scaling,
// followed by three passes through one saturating 64-bit adder. An ignored link goes
// straight to the final step. A link marked last waits in its final step while the output
// register still holds a result that has not been taken. Configuration is written only
// while the block is idle.
module harmonic_path_action_difference_top #(
    parameter int ACTIVE_DIMS   = 3,
    parameter int MAX_PARTICLES = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // link input
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_kind,
    input  logic [9:0]                        i_particle,
    input  logic signed [23:0]                i_r0_x,
    input  logic signed [23:0]                i_r0_y,
    input  logic signed [23:0]                i_r0_z,
    input  logic signed [23:0]                i_r1_x,
    input  logic signed [23:0]                i_r1_y,
    input  logic signed [23:0]                i_r1_z,
    input  logic                              i_last,
    // result output
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [63:0]                o_action_delta,
    output logic                              o_saturated,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hpad_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hpad_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam logic [1:0] DIM_FIRST = 2'(hpad_pkg::NUM_DIMS - ACTIVE_DIMS);
    localparam logic [1:0] DIM_LAST  = 2'(hpad_pkg::NUM_DIMS - 1);

    // configuration registers
    logic signed [hpad_pkg::COORD_W-1:0] r_center [hpad_pkg::NUM_DIMS];
    logic [hpad_pkg::COEF_W-1:0]         r_coef   [3];
    logic [9:0]                          r_first;
    logic [10:0]                         r_count;

    // link state
    hpad_pkg::t_state                    r_state, n_state;
    logic                                r_kind;
    logic                                r_last;
    logic signed [hpad_pkg::CTR_W-1:0]   r_a [hpad_pkg::NUM_DIMS];
    logic signed [hpad_pkg::CTR_W-1:0]   r_b [hpad_pkg::NUM_DIMS];
    logic [1:0]                          r_dim;
    logic [1:0]                          r_sel;
    logic [1:0]                          r_ci;
    logic                                r_half;
    logic signed [hpad_pkg::SUM_W-1:0]   r_aa, r_ab, r_bb;
    logic signed [hpad_pkg::DOT_W-1:0]   r_dot  [3];
    logic [hpad_pkg::ACC_W-1:0]          r_lo;
    logic signed [hpad_pkg::ACC_W-1:0]   r_term [3];
    logic signed [hpad_pkg::ACC_W-1:0]   r_link;
    logic signed [hpad_pkg::ACC_W-1:0]   r_acc;
    logic                                r_sat;

    // shared multiplier
    logic signed [hpad_pkg::MUL_W-1:0]   w_op_a, w_op_b;
    logic signed [hpad_pkg::PROD_W-1:0]  w_prod, r_prod;
    hpad_pkg::t_mtag                     n_tag, r_tag;

    // output register
    logic                                r_out_valid;
    logic signed [hpad_pkg::ACC_W-1:0]   r_out_delta;
    logic                                r_out_sat;

    logic signed [hpad_pkg::COORD_W-1:0] w_r0 [hpad_pkg::NUM_DIMS];
    logic signed [hpad_pkg::COORD_W-1:0] w_r1 [hpad_pkg::NUM_DIMS];
    logic                                w_accept;
    logic                                w_in_range;
    logic                                w_emit;
    logic                                w_tag_drained;
    logic signed [7:0]                   w_hi;
    logic signed [40:0]                  w_hi_prod;
    logic signed [hpad_pkg::FULL_W-1:0]  w_full;
    hpad_pkg::t_sat                      w_scale;
    logic signed [hpad_pkg::ACC_W-1:0]   w_cmb_a, w_cmb_b;
    logic                                w_cmb_sub;
    logic                                w_cmb_en;
    hpad_pkg::t_sat                      w_cmb;
    logic signed [hpad_pkg::SUM_W+1:0]   w_d2_full;

    assign w_r0[0] = i_r0_x;
    assign w_r0[1] = i_r0_y;
    assign w_r0[2] = i_r0_z;
    assign w_r1[0] = i_r1_x;
    assign w_r1[1] = i_r1_y;
    assign w_r1[2] = i_r1_z;

    // handshakes
    assign o_stall        = (r_state != hpad_pkg::ST_IDLE);
    assign o_cfg_ready    = (r_state == hpad_pkg::ST_IDLE);
    assign w_accept       = i_valid && !o_stall;
    assign o_valid        = r_out_valid;
    assign o_action_delta = r_out_delta;
    assign o_saturated    = r_out_sat;

    // particle range check
    assign w_in_range = (i_particle >= r_first)
                     && (12'(i_particle) < (12'(r_first) + 12'(r_count)))
                     && (int'(i_particle) < MAX_PARTICLES);

    assign w_emit = (r_state == hpad_pkg::ST_FIN) && r_last && (!r_out_valid || !i_stall);
    assign w_tag_drained = !r_tag.vld;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hpad_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_in_range ? hpad_pkg::ST_DOT : hpad_pkg::ST_FIN;
                end
            end
            hpad_pkg::ST_DOT: begin
                if (r_dim == DIM_LAST && r_sel == 2'd2) begin
                    n_state = hpad_pkg::ST_TRUNC;
                end
            end
            hpad_pkg::ST_TRUNC: begin
                if (w_tag_drained) begin
                    n_state = hpad_pkg::ST_SCALE;
                end
            end
            hpad_pkg::ST_SCALE: begin
                if (r_ci == 2'd2 && r_half) begin
                    n_state = hpad_pkg::ST_SUB1;
                end
            end
            hpad_pkg::ST_SUB1: n_state = hpad_pkg::ST_SUB2;
            hpad_pkg::ST_SUB2: n_state = hpad_pkg::ST_ACC;
            hpad_pkg::ST_ACC:  n_state = hpad_pkg::ST_FIN;
            hpad_pkg::ST_FIN: begin
                if (!r_last || w_emit) begin
                    n_state = hpad_pkg::ST_IDLE;
                end
            end
            default: n_state = hpad_pkg::ST_IDLE;
        endcase
    end

    // multiplier operand selection and tag of the product
    always_comb begin
        w_op_a    = '0;
        w_op_b    = '0;
        w_hi      = r_dot[r_ci][hpad_pkg::DOT_W-1:32];
        n_tag.vld = 1'b0;
        n_tag.op  = hpad_pkg::MOP_AA;
        n_tag.ci  = r_ci;
        case (r_state)
            hpad_pkg::ST_DOT: begin
                n_tag.vld = 1'b1;
                case (r_sel)
                    2'd0: begin
                        w_op_a   = hpad_pkg::MUL_W'(r_a[r_dim]);
                        w_op_b   = hpad_pkg::MUL_W'(r_a[r_dim]);
                        n_tag.op = hpad_pkg::MOP_AA;
                    end
                    2'd1: begin
                        w_op_a   = hpad_pkg::MUL_W'(r_a[r_dim]);
                        w_op_b   = hpad_pkg::MUL_W'(r_b[r_dim]);
                        n_tag.op = hpad_pkg::MOP_AB;
                    end
                    default: begin
                        w_op_a   = hpad_pkg::MUL_W'(r_b[r_dim]);
                        w_op_b   = hpad_pkg::MUL_W'(r_b[r_dim]);
                        n_tag.op = hpad_pkg::MOP_BB;
                    end
                endcase
            end
            hpad_pkg::ST_SCALE: begin
                n_tag.vld = 1'b1;
                w_op_a    = {1'b0, r_coef[r_ci]};
                if (r_half) begin
                    w_op_b   = hpad_pkg::MUL_W'(w_hi);
                    n_tag.op = hpad_pkg::MOP_HI;
                end else begin
                    w_op_b   = {1'b0, r_dot[r_ci][31:0]};
                    n_tag.op = hpad_pkg::MOP_LO;
                end
            end
            default: begin
                n_tag.vld = 1'b0;
            end
        endcase
    end

    assign w_prod = w_op_a * w_op_b;

    // recombine the split scaling product and clamp to 64 bits
    assign w_hi_prod = r_prod[40:0];
    assign w_full = $signed({8'b0, r_lo}) + (hpad_pkg::FULL_W'(w_hi_prod) <<< 32);
    always_comb begin
        if (w_full[hpad_pkg::FULL_W-1:hpad_pkg::ACC_W-1] == '0
            || w_full[hpad_pkg::FULL_W-1:hpad_pkg::ACC_W-1] == '1) begin
            w_scale.val = w_full[hpad_pkg::ACC_W-1:0];
            w_scale.ovf = 1'b0;
        end else begin
            w_scale.val = w_full[hpad_pkg::FULL_W-1] ? hpad_pkg::ACC_MIN : hpad_pkg::ACC_MAX;
            w_scale.ovf = 1'b1;
        end
    end

    // shared saturating adder for the combine steps
    always_comb begin
        w_cmb_a   = r_acc;
        w_cmb_b   = r_link;
        w_cmb_sub = r_kind;
        w_cmb_en  = 1'b0;
        case (r_state)
            hpad_pkg::ST_SUB1: begin
                w_cmb_a   = r_term[0];
                w_cmb_b   = r_term[1];
                w_cmb_sub = 1'b1;
                w_cmb_en  = 1'b1;
            end
            hpad_pkg::ST_SUB2: begin
                w_cmb_a   = r_link;
                w_cmb_b   = r_term[2];
                w_cmb_sub = 1'b1;
                w_cmb_en  = 1'b1;
            end
            hpad_pkg::ST_ACC: begin
                w_cmb_en  = 1'b1;
            end
            default: begin
                w_cmb_en  = 1'b0;
            end
        endcase
    end

    assign w_cmb = hpad_pkg::f_sat_addsub(w_cmb_a, w_cmb_b, w_cmb_sub);

    // squared step length from the three dot sums
    assign w_d2_full = (hpad_pkg::SUM_W+2)'(r_aa) + (hpad_pkg::SUM_W+2)'(r_bb)
                     - ((hpad_pkg::SUM_W+2)'(r_ab) <<< 1);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < hpad_pkg::NUM_DIMS; d++) begin
                r_center[d] <= '0;
            end
            for (int c = 0; c < 3; c++) begin
                r_coef[c] <= '0;
            end
            r_first <= '0;
            r_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                hpad_pkg::CFG_CENTER_X:       r_center[0] <= i_cfg_data[23:0];
                hpad_pkg::CFG_CENTER_Y:       r_center[1] <= i_cfg_data[23:0];
                hpad_pkg::CFG_CENTER_Z:       r_center[2] <= i_cfg_data[23:0];
                hpad_pkg::CFG_COEF_DIAG:      r_coef[0]   <= i_cfg_data;
                hpad_pkg::CFG_COEF_CROSS:     r_coef[1]   <= i_cfg_data;
                hpad_pkg::CFG_COEF_KIN:       r_coef[2]   <= i_cfg_data;
                hpad_pkg::CFG_FIRST_PARTICLE: r_first     <= i_cfg_data[9:0];
                hpad_pkg::CFG_PARTICLE_COUNT: r_count     <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // sequencer, multiplier pipeline and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hpad_pkg::ST_IDLE;
            r_tag       <= '0;
            r_acc       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tag   <= n_tag;

            // accumulator and sticky saturation flag
            if (w_emit) begin
                r_acc <= '0;
                r_sat <= 1'b0;
            end else begin
                if (r_state == hpad_pkg::ST_ACC) begin
                    r_acc <= w_cmb.val;
                end
                r_sat <= r_sat
                       | (r_tag.vld && r_tag.op == hpad_pkg::MOP_HI && w_scale.ovf)
                       | (w_cmb_en && w_cmb.ovf);
            end

            // output register
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;

        if (w_emit) begin
            r_out_delta <= r_acc;
            r_out_sat   <= r_sat;
        end

        // link capture with the centre taken off
        if (w_accept) begin
            r_kind <= i_kind;
            r_last <= i_last;
            for (int d = 0; d < hpad_pkg::NUM_DIMS; d++) begin
                r_a[d] <= hpad_pkg::CTR_W'(w_r0[d]) - hpad_pkg::CTR_W'(r_center[d]);
                r_b[d] <= hpad_pkg::CTR_W'(w_r1[d]) - hpad_pkg::CTR_W'(r_center[d]);
            end
            r_aa  <= '0;
            r_ab  <= '0;
            r_bb  <= '0;
            r_dim <= DIM_FIRST;
            r_sel <= 2'd0;
        end

        // walk the dimensions, three products each
        if (r_state == hpad_pkg::ST_DOT) begin
            if (r_sel == 2'd2) begin
                r_sel <= 2'd0;
                r_dim <= r_dim + 2'd1;
            end else begin
                r_sel <= r_sel + 2'd1;
            end
        end

        // floor each dot sum to 16 fraction bits
        if (r_state == hpad_pkg::ST_TRUNC && w_tag_drained) begin
            r_dot[0] <= hpad_pkg::DOT_W'(r_aa >>> hpad_pkg::FRAC_W)
                      + hpad_pkg::DOT_W'(r_bb >>> hpad_pkg::FRAC_W);
            r_dot[1] <= hpad_pkg::DOT_W'(r_ab >>> hpad_pkg::FRAC_W);
            r_dot[2] <= hpad_pkg::DOT_W'(w_d2_full >>> hpad_pkg::FRAC_W);
            r_ci     <= 2'd0;
            r_half   <= 1'b0;
        end

        // walk the coefficients, low half then high half
        if (r_state == hpad_pkg::ST_SCALE) begin
            r_half <= !r_half;
            if (r_half) begin
                r_ci <= r_ci + 2'd1;
            end
        end

        // retire the product in flight
        if (r_tag.vld) begin
            case (r_tag.op)
                hpad_pkg::MOP_AA: r_aa <= r_aa + hpad_pkg::SUM_W'(r_prod);
                hpad_pkg::MOP_AB: r_ab <= r_ab + hpad_pkg::SUM_W'(r_prod);
                hpad_pkg::MOP_BB: r_bb <= r_bb + hpad_pkg::SUM_W'(r_prod);
                hpad_pkg::MOP_LO: r_lo <= r_prod[hpad_pkg::ACC_W-1:0];
                hpad_pkg::MOP_HI: r_term[r_tag.ci] <= w_scale.val;
                default: ;
            endcase
        end

        // difference terms of the link action
        if (r_state == hpad_pkg::ST_SUB1 || r_state == hpad_pkg::ST_SUB2) begin
            r_link <= w_cmb.val;
        end
    end

`include "harmonic_path_action_difference_top_macros.svh"

    // products in flight only while the multiplier phases can retire them
    `HPAD_ASSERT(a_tag_phase, !r_tag.vld || r_state == hpad_pkg::ST_DOT || r_state == hpad_pkg::ST_TRUNC || r_state == hpad_pkg::ST_SCALE || r_state == hpad_pkg::ST_SUB1, "product in flight outside multiplier phases")
    // a result transfer leaves the accumulator cleared
    `HPAD_ASSERT_NEXT(a_emit_clears, w_emit, r_acc == '0 && !r_sat && o_valid, "accumulator not cleared after result")
    // a new result only comes from the final step of a link
    `HPAD_ASSERT(a_out_source, !$rose(o_valid) || $past(r_state == hpad_pkg::ST_FIN), "result raised outside final step")

endmodule
